// ----- sv/obb_particle_pushout_unit_defines.svh -----
// Assertion macros for the OBB particle push-out unit.
`ifndef OBB_PARTICLE_PUSHOUT_UNIT_DEFINES_SVH
`define OBB_PARTICLE_PUSHOUT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define OBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define OBB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/obbpp_pkg.sv -----
// Shared constants and types of the OBB particle push-out unit.
package obbpp_pkg;
    localparam int CW    = 32;        // coordinate width, Q16.16
    localparam int QW    = 16;        // quaternion component width, Q2.14
    localparam int QF    = QW - 2;    // quaternion fraction bits
    localparam int MW    = 20;        // rotation matrix entry width, Q.14
    localparam int REGW  = 32;        // config register width
    localparam int DW    = CW + 1;    // center offset / inflated half-extent
    localparam int LW    = DW + MW + 2 - QF;  // box-space coordinate
    localparam int PW2   = DW + 1;    // pushed box-space coordinate
    localparam int BW    = PW2 + MW + 2 - QF; // rotated-back offset
    localparam int NSTG  = 10;        // pipeline depth

    localparam logic [REGW-1:0] ROT_WX_RST = REGW'(1) << QF; // w = 1.0

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5,
        REG_ROT_WX   = 3'd6,
        REG_ROT_YZ   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef logic [2:0][2:0][MW-1:0] t_mat;

    typedef struct packed {
        logic  pushed;
        t_axis axis;
    } t_push;

    typedef struct packed {
        logic [2:0][CW-1:0] pos;
        logic               pin;
    } t_side;
endpackage

// ----- sv/obbpp_qmat.sv -----
// Rotation matrix built from the box quaternion, registered.
module obbpp_qmat (
    input  logic                        i_clk,
    input  logic [obbpp_pkg::REGW-1:0]  i_rot_wx,
    input  logic [obbpp_pkg::REGW-1:0]  i_rot_yz,
    output obbpp_pkg::t_mat             o_mat
);
    import obbpp_pkg::*;

    localparam int TW = 2 * QW + 4;
    localparam logic signed [TW-1:0] QHALF = TW'(1) <<< (QF - 1);

    logic signed [QW-1:0]   q_w, q_x, q_y, q_z;
    logic signed [2*QW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [TW-1:0]   t [3][3];
    logic signed [TW-1:0]   rnd [3][3];
    t_mat                   n_mat, r_mat;

    always_comb begin
        q_w = $signed(i_rot_wx[QW-1:0]);
        q_x = $signed(i_rot_wx[2*QW-1:QW]);
        q_y = $signed(i_rot_yz[QW-1:0]);
        q_z = $signed(i_rot_yz[2*QW-1:QW]);
        ww = q_w * q_w;  xx = q_x * q_x;  yy = q_y * q_y;  zz = q_z * q_z;
        xy = q_x * q_y;  xz = q_x * q_z;  yz = q_y * q_z;
        wx = q_w * q_x;  wy = q_w * q_y;  wz = q_w * q_z;
        t[0][0] = TW'(ww) + TW'(xx) - TW'(yy) - TW'(zz);
        t[1][1] = TW'(ww) - TW'(xx) + TW'(yy) - TW'(zz);
        t[2][2] = TW'(ww) - TW'(xx) - TW'(yy) + TW'(zz);
        // off-diagonal terms carry the factor two
        t[0][1] = (TW'(xy) - TW'(wz)) <<< 1;
        t[1][0] = (TW'(xy) + TW'(wz)) <<< 1;
        t[0][2] = (TW'(xz) + TW'(wy)) <<< 1;
        t[2][0] = (TW'(xz) - TW'(wy)) <<< 1;
        t[1][2] = (TW'(yz) - TW'(wx)) <<< 1;
        t[2][1] = (TW'(yz) + TW'(wx)) <<< 1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rnd[i][j]   = t[i][j] + QHALF;
                n_mat[i][j] = rnd[i][j][QF+MW-1:QF];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;
endmodule

// ----- sv/obbpp_rot.sv -----
// Matrix-vector rotation: product stage, then sum and round stage.
module obbpp_rot #(
    parameter int VW = obbpp_pkg::DW
) (
    input  logic                                                     i_clk,
    input  logic [1:0]                                               i_en,
    input  obbpp_pkg::t_mat                                          i_mat,
    input  logic [2:0][VW-1:0]                                       i_vec,
    output logic [2:0][VW+obbpp_pkg::MW+2-obbpp_pkg::QF-1:0]        o_vec
);
    import obbpp_pkg::*;

    localparam int PW = VW + MW;
    localparam int SW = PW + 2;
    localparam int OW = SW - QF;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (QF - 1);

    logic signed [PW-1:0] r_prod [3][3];
    logic signed [SW-1:0] sum [3];
    logic [2:0][OW-1:0]   n_out, r_out;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(i_mat[i][j]) * $signed(i_vec[j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i]   = SW'(r_prod[i][0]) + SW'(r_prod[i][1]) + SW'(r_prod[i][2]) + RND;
            n_out[i] = sum[i][SW-1:QF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_vec = r_out;
endmodule

// ----- sv/obbpp_esc.sv -----
// Penetration test, least-escape axis choice and face snap (three stages).
module obbpp_esc (
    input  logic                              i_clk,
    input  logic [2:0]                        i_en,
    input  logic [2:0][obbpp_pkg::LW-1:0]     i_loc,
    input  logic [2:0][obbpp_pkg::DW-1:0]     i_eff,
    input  logic                              i_pin,
    output logic [2:0][obbpp_pkg::PW2-1:0]    o_loc,
    output obbpp_pkg::t_push                  o_push
);
    import obbpp_pkg::*;

    localparam int AW = LW + 1;
    localparam int EW = AW + 1;

    // stage A: magnitudes
    logic signed [AW-1:0] ext [3];
    logic signed [AW-1:0] n_abs [3];
    logic signed [AW-1:0] r_abs4 [3];
    logic [2:0][LW-1:0]   r_loc4;
    logic [2:0][DW-1:0]   r_eff4;
    logic                 r_pin4;

    // stage B: escape distances
    logic signed [EW-1:0] r_esc [3];
    logic [2:0]           n_in;
    logic                 r_pen;
    logic [2:0][LW-1:0]   r_loc5;
    logic [2:0][DW-1:0]   r_eff5;

    // stage C: axis and snapped coordinate
    logic                 a01, sel2;
    logic signed [EW-1:0] best01;
    t_axis                n_axis;
    logic signed [PW2-1:0] effx [3];
    logic [2:0][PW2-1:0]  n_loc, r_loc6;
    t_push                r_push;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext[i]   = AW'($signed(i_loc[i]));
            n_abs[i] = ext[i][AW-1] ? -ext[i] : ext[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_abs4[i] <= n_abs[i];
            end
            r_loc4 <= i_loc;
            r_eff4 <= i_eff;
            r_pin4 <= i_pin;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_in[i] = r_abs4[i] < AW'($signed(r_eff4[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_esc[i] <= EW'($signed(r_eff4[i])) - EW'(r_abs4[i]);
            end
            r_pen  <= (&n_in) & ~r_pin4;
            r_loc5 <= r_loc4;
            r_eff5 <= r_eff4;
        end
    end

    // ties keep the lower axis
    always_comb begin
        a01    = r_esc[1] < r_esc[0];
        best01 = a01 ? r_esc[1] : r_esc[0];
        sel2   = r_esc[2] < best01;
        priority if (sel2) begin
            n_axis = AXIS_Z;
        end else if (a01) begin
            n_axis = AXIS_Y;
        end else begin
            n_axis = AXIS_X;
        end
        for (int i = 0; i < 3; i++) begin
            effx[i] = PW2'($signed(r_eff5[i]));
            if (2'(i) == n_axis) begin
                // zero counts as positive
                n_loc[i] = r_loc5[i][LW-1] ? -effx[i] : effx[i];
            end else begin
                n_loc[i] = r_loc5[i][PW2-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_loc6        <= n_loc;
            r_push.pushed <= r_pen;
            r_push.axis   <= r_pen ? n_axis : AXIS_X;
        end
    end

    assign o_loc  = r_loc6;
    assign o_push = r_push;
endmodule

// ----- sv/obb_particle_pushout_unit.sv -----
// Top level of the OBB particle push-out unit: config, pipeline control, output stage.
//
//  channel   dir   handshake               payload
//  s (in)    in    i_s_tvalid/o_s_tready   tdata pos_x,pos_y,pos_z,radius; tuser is_pinned
//  m (out)   out   o_m_tvalid/i_m_tready   tdata new_x,new_y,new_z; tuser was_pushed,push_axis
//  cfg       in    i_cfg_we                i_cfg_addr register index, i_cfg_data value
//
// One particle per cycle sustained while the receiver keeps i_m_tready high.
// Ten register stages: input, offset/inflate, two for the inverse rotation, three for
// the penetration test and face snap, two for the forward rotation, output.
// Each stage has a valid bit and loads when it is empty or the stage after it moves,
// so bubbles close up and a stalled output only holds the stages behind it.
// The rotation matrix is rebuilt in one registered step from the quaternion registers.
// Synchronous active-low reset clears valid bits and config (rotation to identity).
`include "obb_particle_pushout_unit_defines.svh"

module obb_particle_pushout_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,   // pos_x, pos_y, pos_z, particle_radius
    input  logic [0:0]    i_s_tuser,   // is_pinned
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [95:0]   o_m_tdata,   // new_x, new_y, new_z
    output logic [2:0]    o_m_tuser    // was_pushed, push_axis[1:0]
);
    import obbpp_pkg::*;

    localparam int OSW = BW + 1;
    localparam logic signed [OSW-1:0] SAT_HI = OSW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [OSW-1:0] SAT_LO = ~SAT_HI;

    // config registers
    logic signed [REGW-1:0] r_center [3];
    logic signed [REGW-1:0] r_half [3];
    logic [REGW-1:0]        r_rot_wx, r_rot_yz;

    // pipeline control
    logic [NSTG-1:0] w_en, r_v, n_v;

    // payload lines
    t_side               r_side [9];
    logic [CW-1:0]       r_rad;
    logic [2:0][DW-1:0]  r_d;
    logic [2:0][DW-1:0]  r_eff [1:3];
    logic [2:0][DW-1:0]  n_d, n_eff;
    logic signed [CW-1:0] rad_c;
    t_push               r_push [7:8];

    t_mat                w_mat, w_mat_t;
    logic [2:0][LW-1:0]  w_loc;
    logic [2:0][PW2-1:0] w_snap;
    t_push               w_push;
    logic [2:0][BW-1:0]  w_back;

    logic signed [OSW-1:0] osum [3];
    logic [2:0][CW-1:0]    n_new, r_new;
    logic                  r_pushed;
    t_axis                 r_axis;

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_center[i] <= '0;
                r_half[i]   <= '0;
            end
            r_rot_wx <= ROT_WX_RST;
            r_rot_yz <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_CENTER_X: r_center[0] <= i_cfg_data;
                REG_CENTER_Y: r_center[1] <= i_cfg_data;
                REG_CENTER_Z: r_center[2] <= i_cfg_data;
                REG_HALF_X:   r_half[0]   <= i_cfg_data;
                REG_HALF_Y:   r_half[1]   <= i_cfg_data;
                REG_HALF_Z:   r_half[2]   <= i_cfg_data;
                REG_ROT_WX:   r_rot_wx    <= i_cfg_data;
                REG_ROT_YZ:   r_rot_yz    <= i_cfg_data;
                default:      r_rot_yz    <= r_rot_yz;
            endcase
        end
    end

    // ---------------- stage enables and valid bits ----------------
    always_comb begin
        w_en[NSTG-1] = ~r_v[NSTG-1] | i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = ~r_v[k] | w_en[k+1];
        end
        n_v[0] = w_en[0] ? i_s_tvalid : r_v[0];
        for (int k = 1; k < NSTG; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_s_tready = w_en[0];

    // ---------------- stage 0: input capture ----------------
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0].pos[0] <= i_s_tdata[CW-1:0];
            r_side[0].pos[1] <= i_s_tdata[2*CW-1:CW];
            r_side[0].pos[2] <= i_s_tdata[3*CW-1:2*CW];
            r_side[0].pin    <= i_s_tuser[0];
            r_rad            <= i_s_tdata[4*CW-1:3*CW];
        end
    end

    // ---------------- stage 1: offset from center, inflated half-extents ----------------
    always_comb begin
        rad_c = $signed(r_rad);
        if (rad_c[CW-1]) begin
            rad_c = '0;   // negative radius acts as zero
        end
        for (int i = 0; i < 3; i++) begin
            n_d[i]   = DW'($signed(r_side[0].pos[i])) - DW'(r_center[i]);
            n_eff[i] = DW'(r_half[i]) + DW'(rad_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_d      <= n_d;
            r_eff[1] <= n_eff;
        end
        for (int k = 2; k <= 3; k++) begin
            if (w_en[k]) begin
                r_eff[k] <= r_eff[k-1];
            end
        end
        for (int k = 1; k <= 8; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_en[7]) begin
            r_push[7] <= w_push;
        end
        if (w_en[8]) begin
            r_push[8] <= r_push[7];
        end
    end

    // ---------------- rotation matrix ----------------
    obbpp_qmat u_qmat (
        .i_clk    (i_clk),
        .i_rot_wx (r_rot_wx),
        .i_rot_yz (r_rot_yz),
        .o_mat    (w_mat)
    );

    // box space uses the transpose (conjugate rotation)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_mat_t[i][j] = w_mat[j][i];
            end
        end
    end

    // ---------------- stages 2-3: world to box space ----------------
    obbpp_rot #(.VW(DW)) u_rot_in (
        .i_clk (i_clk),
        .i_en  (w_en[3:2]),
        .i_mat (w_mat_t),
        .i_vec (r_d),
        .o_vec (w_loc)
    );

    // ---------------- stages 4-6: penetration test and snap ----------------
    obbpp_esc u_esc (
        .i_clk  (i_clk),
        .i_en   (w_en[6:4]),
        .i_loc  (w_loc),
        .i_eff  (r_eff[3]),
        .i_pin  (r_side[3].pin),
        .o_loc  (w_snap),
        .o_push (w_push)
    );

    // ---------------- stages 7-8: box to world space ----------------
    obbpp_rot #(.VW(PW2)) u_rot_out (
        .i_clk (i_clk),
        .i_en  (w_en[8:7]),
        .i_mat (w_mat),
        .i_vec (w_snap),
        .o_vec (w_back)
    );

    // ---------------- stage 9: re-center, saturate, select ----------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            osum[i] = OSW'(r_center[i]) + OSW'($signed(w_back[i]));
            priority if (!r_push[8].pushed) begin
                n_new[i] = r_side[8].pos[i];
            end else if (osum[i] > SAT_HI) begin
                n_new[i] = SAT_HI[CW-1:0];
            end else if (osum[i] < SAT_LO) begin
                n_new[i] = SAT_LO[CW-1:0];
            end else begin
                n_new[i] = osum[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_new    <= n_new;
            r_pushed <= r_push[8].pushed;
            r_axis   <= r_push[8].axis;
        end
    end

    assign o_m_tvalid = r_v[NSTG-1];
    assign o_m_tdata  = {r_new[2], r_new[1], r_new[0]};
    assign o_m_tuser  = {r_axis, r_pushed};

    // ---------------- assertions ----------------
    `OBB_ASSERT_IMP(a_ready_when_empty, !r_v[0], o_s_tready, "input stage empty but not ready")
    `OBB_ASSERT_IMP(a_axis_unpushed, o_m_tvalid && !o_m_tuser[0], o_m_tuser[2:1] == AXIS_X, "axis set on unpushed result")
    `OBB_ASSERT_NXT(a_stage_advance, r_v[NSTG-2] && w_en[NSTG-1], o_m_tvalid, "item lost entering output stage")
endmodule

// ----- bench/obb_particle_pushout_unit_checker.sv -----
// Checker for the OBB push-out unit: mirrors config, predicts each particle, compares results.
`timescale 1ns / 1ps

module obb_particle_pushout_unit_checker
    import obbpp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic [0:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [95:0]  i_m_tdata,
    input  logic [2:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        pushed;
        t_axis       axis;
    } t_resolved;

    logic [31:0] box_reg [8];
    t_resolved   resolved_q [$];

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Box-space resolve: inverse rotate, strict in-box test, snap to nearest face, rotate back.
    function automatic t_resolved resolve_particle(logic [127:0] data, logic pin);
        longint    pos [3], ctr [3], d [3], loc [3], eff [3], back [3];
        longint    t [3][3], m [3][3];
        longint    w, x, y, z, r, best, esc, acc;
        int        ax;
        bit        in_box;
        t_resolved res;
        for (int i = 0; i < 3; i++) begin
            pos[i] = $signed(data[32*i +: 32]);
            ctr[i] = $signed(box_reg[REG_CENTER_X + i]);
        end
        res = '{x: data[31:0], y: data[63:32], z: data[95:64], pushed: 1'b0, axis: AXIS_X};
        if (pin) return res;
        r = $signed(data[127:96]);
        if (r < 0) r = 0;
        for (int i = 0; i < 3; i++) begin
            d[i]   = pos[i] - ctr[i];
            eff[i] = longint'($signed(box_reg[REG_HALF_X + i])) + r;
        end
        w = $signed(box_reg[REG_ROT_WX][15:0]);
        x = $signed(box_reg[REG_ROT_WX][31:16]);
        y = $signed(box_reg[REG_ROT_YZ][15:0]);
        z = $signed(box_reg[REG_ROT_YZ][31:16]);
        t[0][0] = w*w + x*x - y*y - z*z;
        t[1][1] = w*w - x*x + y*y - z*z;
        t[2][2] = w*w - x*x - y*y + z*z;
        t[0][1] = x*y - w*z;
        t[1][0] = x*y + w*z;
        t[0][2] = x*z + w*y;
        t[2][0] = x*z - w*y;
        t[1][2] = y*z - w*x;
        t[2][1] = y*z + w*x;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (((i == j) ? t[i][j] : 2*t[i][j]) + 8192) >>> 14;
        // transpose rotates into box space
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m[j][i] * d[j];
            loc[i] = (acc + 8192) >>> 14;
        end
        in_box = 1'b1;
        for (int i = 0; i < 3; i++)
            if (!(mag(loc[i]) < eff[i])) in_box = 1'b0;
        if (!in_box) return res;
        ax   = 0;
        best = eff[0] - mag(loc[0]);
        for (int i = 1; i < 3; i++) begin
            esc = eff[i] - mag(loc[i]);
            if (esc < best) begin   // ties keep the lower axis
                best = esc;
                ax   = i;
            end
        end
        loc[ax] = (loc[ax] >= 0) ? eff[ax] : -eff[ax];
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m[i][j] * loc[j];
            back[i] = (acc + 8192) >>> 14;
        end
        res.x      = clamp32(ctr[0] + back[0]);
        res.y      = clamp32(ctr[1] + back[1]);
        res.z      = clamp32(ctr[2] + back[2]);
        res.pushed = 1'b1;
        res.axis   = t_axis'(ax);
        return res;
    endfunction

    assign o_pending = resolved_q.size();

    always @(posedge i_clk) begin
        t_resolved exp_r;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++)
                box_reg[i] <= (i == REG_ROT_WX) ? ROT_WX_RST : '0;
            resolved_q.delete();
        end else begin
            if (i_cfg_we) box_reg[i_cfg_addr] <= i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                resolved_q.push_back(resolve_particle(i_s_tdata, i_s_tuser[0]));
            if (i_m_tvalid && i_m_tready) begin
                if (resolved_q.size() == 0) begin
                    $error("result transfer with no particle outstanding");
                    errs++;
                end else begin
                    exp_r = resolved_q.pop_front();
                    if (i_m_tdata[31:0] !== exp_r.x) begin
                        $error("new_x exp %h got %h", exp_r.x, i_m_tdata[31:0]);
                        errs++;
                    end
                    if (i_m_tdata[63:32] !== exp_r.y) begin
                        $error("new_y exp %h got %h", exp_r.y, i_m_tdata[63:32]);
                        errs++;
                    end
                    if (i_m_tdata[95:64] !== exp_r.z) begin
                        $error("new_z exp %h got %h", exp_r.z, i_m_tdata[95:64]);
                        errs++;
                    end
                    if (i_m_tuser[0] !== exp_r.pushed) begin
                        $error("was_pushed exp %b got %b", exp_r.pushed, i_m_tuser[0]);
                        errs++;
                    end
                    if (i_m_tuser[2:1] !== exp_r.axis) begin
                        $error("push_axis exp %0d got %0d", exp_r.axis, i_m_tuser[2:1]);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ----- bench/obb_particle_pushout_unit_test.sv -----
// Testbench top of the OBB push-out unit: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module obb_particle_pushout_unit_test;
    import obbpp_pkg::*;

    localparam int ONE      = 32'h0001_0000;   // 1.0 in Q16.16
    localparam int WD_LIMIT = 3000;            // cycles with no transfer at all

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [31:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;   // pos_x, pos_y, pos_z, particle_radius
    logic [0:0]   i_s_tuser;   // is_pinned
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [95:0]  o_m_tdata;   // new_x, new_y, new_z
    logic [2:0]   o_m_tuser;   // was_pushed, push_axis[1:0]

    int fail_count;
    int pending;
    bit idle_en;      // random bursts of idling on both sides
    bit hold_req;     // one long receiver hold-off
    int stall_cycles;

    obb_particle_pushout_unit u_dut (.*);

    obb_particle_pushout_unit_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WD_LIMIT) begin
            $display("obb_particle_pushout_unit test failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when idling is off.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (60) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Reconfigure the box once the pipe has drained, then let the matrix register pick up the new quaternion.
    task automatic load_box(logic [31:0] cx, cy, cz, hx, hy, hz, wx, yz);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (NSTG + 2) @(posedge i_clk);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_HALF_X, hx);
        write_reg(REG_HALF_Y, hy);
        write_reg(REG_HALF_Z, hz);
        write_reg(REG_ROT_WX, wx);
        write_reg(REG_ROT_YZ, yz);
        i_cfg_we <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    // One particle transfer, with an optional idle burst ahead of it.
    task automatic send_particle(logic [31:0] px, py, pz, rad, logic pin);
        bit taken;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {rad, pz, py, px};
        i_s_tuser  <= pin;
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Mostly near the box (inside or just outside), some fully random words.
    task automatic random_particles(int count, logic [31:0] cx, cy, cz, int span);
        logic [31:0] p [3];
        logic [31:0] rad;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                p[0] = $urandom; p[1] = $urandom; p[2] = $urandom;
            end else begin
                p[0] = cx + $signed($urandom_range(0, 2*span)) - span;
                p[1] = cy + $signed($urandom_range(0, 2*span)) - span;
                p[2] = cz + $signed($urandom_range(0, 2*span)) - span;
            end
            case ($urandom_range(0, 5))
                0: rad = $urandom;
                1: rad = -$urandom_range(0, 4*ONE);
                2: rad = '0;
                default: rad = $urandom_range(0, span / 4);
            endcase
            send_particle(p[0], p[1], p[2], rad, $urandom_range(0, 7) == 0);
        end
    endtask

    function automatic logic [15:0] rand_q();
        return 16'($signed($urandom_range(0, 2*16384)) - 16384);
    endfunction

    initial begin
        logic [31:0] c [3];
        int          span;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: zero half-extents, nothing can penetrate unless the radius inflates.
        send_particle('0, '0, '0, '0, 1'b0);
        send_particle('0, '0, '0, ONE, 1'b0);

        // Axis-aligned 10x10x10 half box at the origin.
        load_box('0, '0, '0, 10*ONE, 10*ONE, 10*ONE, ROT_WX_RST, '0);
        send_particle('0, '0, '0, '0, 1'b0);                   // center: tie, +x face
        send_particle(ONE, 2*ONE, 3*ONE, '0, 1'b0);            // push along z
        send_particle(-9*ONE, ONE, -ONE, '0, 1'b0);            // negative side of x
        send_particle(ONE, -8*ONE, ONE, '0, 1'b0);             // y axis
        send_particle(ONE, 5*ONE, 5*ONE, '0, 1'b0);           // y/z tie keeps y
        send_particle(10*ONE, '0, '0, '0, 1'b0);               // on the face: not in the box
        send_particle(10*ONE, '0, '0, ONE, 1'b0);              // radius brings it in
        send_particle(ONE, ONE, ONE, 32'h8000_0000, 1'b0);     // most negative radius
        send_particle(ONE, ONE, ONE, 32'h7FFF_FFFF, 1'b0);     // huge radius
        send_particle(ONE, ONE, ONE, '0, 1'b1);                // pinned in the box
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b0);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_particle(32'hFFFF_FFFF, 32'h0000_0001, '0, 32'hFFFF_FFFF, 1'b1);

        // 90 degrees about z, offset center.
        load_box(5*ONE, -3*ONE, ONE, 4*ONE, 2*ONE, 6*ONE,
                 32'h0000_2D41, 32'h2D41_0000);
        send_particle(5*ONE, -2*ONE, ONE, '0, 1'b0);
        send_particle(6*ONE, -3*ONE, 2*ONE, '0, 1'b0);
        send_particle(5*ONE, -3*ONE, 6*ONE, ONE/2, 1'b0);

        // Saturating corner: extreme center, max half-extents, extreme non-unit quaternion.
        load_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_7FFF, 32'h7FFF_8000);
        random_particles(40, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF);

        // Negative half-extents: never penetrates unless the radius outweighs them.
        load_box(32'h8000_0000, '0, 32'h7FFF_FFFF, 32'h8000_0000, -ONE, 32'hFFFF_FFFF,
                 {rand_q(), rand_q()}, {rand_q(), rand_q()});
        random_particles(30, 32'h8000_0000, '0, 32'h7FFF_FFFF, 8*ONE);

        // Random boxes; the first one also fills the pipe behind a long output hold-off.
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 3; i++) c[i] = $signed($urandom_range(0, 2000*ONE)) - 1000*ONE;
            span = $urandom_range(1, 200) * ONE;
            load_box(c[0], c[1], c[2], $urandom_range(1, span), $urandom_range(1, span),
                     $urandom_range(1, span), {rand_q(), rand_q()}, {rand_q(), rand_q()});
            if (ph == 0) hold_req = 1'b1;
            if (ph == 5) idle_en = 1'b0;   // closing stretch at full rate
            random_particles(60, c[0], c[1], c[2], 2 * span);
        end

        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (NSTG + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("obb_particle_pushout_unit test passed");
        else
            $display("obb_particle_pushout_unit test failed");
        $finish;
    end

endmodule
